// ===== rtl/nearest_track_matcher_macros.svh =====
// ----------------------------------------------------------------------------
// Nearest track matcher: assertion macros
// Shared property wrappers, clocked on i_clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef NEAREST_TRACK_MATCHER_MACROS_SVH
`define NEAREST_TRACK_MATCHER_MACROS_SVH

// Same-cycle implication
`define NTM_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ntm check failed");

// Next-cycle implication
`define NTM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ntm check failed");

`endif

// ===== rtl/ntm_pkg.sv =====
// ----------------------------------------------------------------------------
// Nearest track matcher package
// Shared widths, codes, reciprocal constants and controller/datapath structs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ntm_pkg;

    localparam int MAX_TRACKS = 32;
    localparam int SLOT_W     = 5;
    localparam int CNT_W      = 6;
    localparam int COORD_W    = 12;
    localparam int CEN_W      = 13;
    localparam int HIST       = 5;
    localparam int HCNT_W     = 3;
    localparam int AGE_W      = 8;

    localparam logic [AGE_W-1:0] LIFETIME_RST = 8'd10;
    localparam logic [AGE_W-1:0] AGE_MAX      = 8'd255;

    // register map, index = byte address / 4
    localparam logic REG_LIFETIME = 1'b0;

    // rounded division by 3, 6, 10: (2a + d) / 2d via multiply by 2^24 / 2d
    localparam int          RECIP_SH = 24;
    localparam logic [24:0] RECIP_1  = 25'd16777216;
    localparam logic [24:0] RECIP_6  = 25'd2796203;
    localparam logic [24:0] RECIP_12 = 25'd1398102;
    localparam logic [24:0] RECIP_20 = 25'd838861;

    typedef enum logic [1:0] {
        OUT_MATCH = 2'd0,
        OUT_NEW   = 2'd1,
        OUT_DROP  = 2'd2,
        OUT_CLOSE = 2'd3
    } t_outcome;

    typedef enum logic [1:0] {
        DIV_1  = 2'd0,
        DIV_3  = 2'd1,
        DIV_6  = 2'd2,
        DIV_10 = 2'd3
    } t_div;

    typedef struct packed {
        logic [HCNT_W-1:0]           cnt;
        logic [HIST-1:0][CEN_W-1:0]  hx;
        logic [HIST-1:0][CEN_W-1:0]  hy;
    } t_row;

    typedef struct packed {
        logic              rd;       // scan read of slot idx
        logic              rd_best;  // read row of best slot
        logic              thr;      // form threshold products
        logic              push;     // append centre to best track
        logic              open;     // open track in lowest free slot
        logic              age;      // age slot idx
        logic              emit;     // load output register
        logic [SLOT_W-1:0] idx;
        t_outcome          outcome;
    } t_cmd;

    typedef struct packed {
        logic pipe_busy;
        logic match;
        logic has_free;
        logic first_frame;
        logic live_zero;
        logic out_hold;
    } t_stat;

endpackage

`default_nettype wire

// ===== rtl/ntm_ctrl.sv =====
// ----------------------------------------------------------------------------
// Nearest track matcher controller
// Sequences the slot scan, match decision, track update and frame ageing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ntm_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_accept,
    input  wire logic          i_kind,
    input  wire ntm_pkg::t_stat i_stat,
    output ntm_pkg::t_cmd      o_cmd,
    output logic               o_idle
);

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN, S_DRAIN, S_THR, S_CMP, S_RDROW, S_PUSH, S_OPEN, S_AGE, S_DONE
    } t_state;

    t_state                       r_state;
    logic [ntm_pkg::SLOT_W-1:0]   r_idx;
    ntm_pkg::t_outcome            r_outcome;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_idx     <= '0;
            r_outcome <= ntm_pkg::OUT_CLOSE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    r_idx <= '0;
                    if (i_accept) begin
                        if (i_kind)
                            r_state <= S_AGE;
                        else if (!i_stat.first_frame && !i_stat.live_zero)
                            r_state <= S_SCAN;
                        else
                            r_state <= S_OPEN;
                    end
                end
                S_SCAN: begin
                    r_idx <= r_idx + 1'b1;
                    if (&r_idx)
                        r_state <= S_DRAIN;
                end
                S_DRAIN: begin
                    if (!i_stat.pipe_busy)
                        r_state <= S_THR;
                end
                S_THR: r_state <= S_CMP;
                S_CMP: r_state <= i_stat.match ? S_RDROW : S_OPEN;
                S_RDROW: r_state <= S_PUSH;
                S_PUSH: begin
                    r_outcome <= ntm_pkg::OUT_MATCH;
                    r_state   <= S_DONE;
                end
                S_OPEN: begin
                    r_outcome <= i_stat.has_free ? ntm_pkg::OUT_NEW : ntm_pkg::OUT_DROP;
                    r_state   <= S_DONE;
                end
                S_AGE: begin
                    r_idx <= r_idx + 1'b1;
                    if (&r_idx) begin
                        r_outcome <= ntm_pkg::OUT_CLOSE;
                        r_state   <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!i_stat.out_hold)
                        r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_comb begin
        o_cmd         = '0;
        o_cmd.idx     = r_idx;
        o_cmd.outcome = r_outcome;
        o_cmd.rd      = (r_state == S_SCAN);
        o_cmd.thr     = (r_state == S_THR);
        o_cmd.rd_best = (r_state == S_RDROW);
        o_cmd.push    = (r_state == S_PUSH);
        o_cmd.open    = (r_state == S_OPEN) && i_stat.has_free;
        o_cmd.age     = (r_state == S_AGE);
        o_cmd.emit    = (r_state == S_DONE) && !i_stat.out_hold;
    end

    assign o_idle = (r_state == S_IDLE);

endmodule

`default_nettype wire

// ===== rtl/ntm_dp.sv =====
// ----------------------------------------------------------------------------
// Nearest track matcher datapath
// Track table, history memory, prediction/distance pipeline, output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ntm_dp (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_load,
    input  wire logic                          i_kind,
    input  wire logic [ntm_pkg::COORD_W-1:0]   i_box_x,
    input  wire logic [ntm_pkg::COORD_W-1:0]   i_box_y,
    input  wire logic [ntm_pkg::COORD_W-1:0]   i_box_width,
    input  wire logic [ntm_pkg::COORD_W-1:0]   i_box_height,
    input  wire logic [ntm_pkg::AGE_W-1:0]     i_lifetime,
    input  wire ntm_pkg::t_cmd                 i_cmd,
    output ntm_pkg::t_stat                     o_stat,
    input  wire logic                          i_out_ready,
    output logic                               o_out_valid,
    output logic [1:0]                         o_outcome,
    output logic [ntm_pkg::SLOT_W-1:0]         o_track_slot,
    output logic [ntm_pkg::CNT_W-1:0]          o_live_tracks
);

    localparam int NT  = ntm_pkg::MAX_TRACKS;
    localparam int SW  = ntm_pkg::SLOT_W;
    localparam int CW  = ntm_pkg::CEN_W;
    localparam int AW  = ntm_pkg::AGE_W;

    // ---------------- track table ----------------
    logic [NT-1:0]          r_valid;
    logic [SW-1:0]          r_order [NT];
    logic [AW-1:0]          r_age   [NT];
    logic [ntm_pkg::CNT_W-1:0] r_live;
    logic                   r_first;

    ntm_pkg::t_row          r_mem [NT];
    ntm_pkg::t_row          r_row;

    logic [CW-1:0]          r_cx, r_cy;
    logic [ntm_pkg::COORD_W-1:0] r_w, r_h;
    logic [23:0]            r_w2, r_h2;

    // ---------------- scan pipeline ----------------
    logic                   r_p0_vld, r_a_vld, r_b_vld, r_c_vld, r_d_vld;
    logic [SW-1:0]          r_p0_idx, r_a_idx, r_b_idx, r_c_idx, r_d_idx;
    logic signed [17:0]     r_a_sx, r_a_sy;
    logic [CW-1:0]          r_a_lx, r_a_ly;
    ntm_pkg::t_div          r_a_div;
    logic [42:0]            r_b_px, r_b_py;
    logic                   r_b_nx, r_b_ny;
    logic [CW-1:0]          r_b_lx, r_b_ly;
    logic signed [15:0]     r_c_dx, r_c_dy;
    logic [27:0]            r_d_sx, r_d_sy;

    logic                   r_found;
    logic [SW-1:0]          r_best;
    logic [SW-1:0]          r_best_order;
    logic [28:0]            r_best_d2;
    logic [37:0]            r_d2_x400, r_lim;
    logic [SW-1:0]          r_res_slot;

    // weighted delta sum collapses to 4h4-h3-h2-h1-h0, 3h3-h2-h1-h0, 2h2-h1-h0, h1-h0
    function automatic logic signed [17:0] axis_sum(
        input logic [ntm_pkg::HIST-1:0][CW-1:0] h,
        input logic [ntm_pkg::HCNT_W-1:0]       n
    );
        logic signed [17:0] v0, v1, v2, v3, v4;
        logic signed [17:0] res;
        v0 = $signed({5'b0, h[0]});
        v1 = $signed({5'b0, h[1]});
        v2 = $signed({5'b0, h[2]});
        v3 = $signed({5'b0, h[3]});
        v4 = $signed({5'b0, h[4]});
        case (n)
            3'd2:    res = v1 - v0;
            3'd3:    res = (v2 <<< 1) - v1 - v0;
            3'd4:    res = (v3 <<< 1) + v3 - v2 - v1 - v0;
            3'd5:    res = (v4 <<< 2) - v3 - v2 - v1 - v0;
            default: res = '0;
        endcase
        return res;
    endfunction

    function automatic logic [CW-1:0] axis_last(
        input logic [ntm_pkg::HIST-1:0][CW-1:0] h,
        input logic [ntm_pkg::HCNT_W-1:0]       n
    );
        logic [CW-1:0] res;
        case (n)
            3'd2:    res = h[1];
            3'd3:    res = h[2];
            3'd4:    res = h[3];
            3'd5:    res = h[4];
            default: res = h[0];
        endcase
        return res;
    endfunction

    function automatic logic [42:0] div_prod(
        input logic signed [17:0] s,
        input ntm_pkg::t_div      dv
    );
        logic [16:0] a;
        logic [17:0] num;
        logic [24:0] m;
        a = s[17] ? 17'(-s) : 17'(s);
        case (dv)
            ntm_pkg::DIV_3:  begin num = {a, 1'b0} + 18'd3;  m = ntm_pkg::RECIP_6;  end
            ntm_pkg::DIV_6:  begin num = {a, 1'b0} + 18'd6;  m = ntm_pkg::RECIP_12; end
            ntm_pkg::DIV_10: begin num = {a, 1'b0} + 18'd10; m = ntm_pkg::RECIP_20; end
            default:         begin num = {1'b0, a};          m = ntm_pkg::RECIP_1;  end
        endcase
        return 43'(num) * 43'(m);
    endfunction

    function automatic logic signed [15:0] axis_diff(
        input logic [CW-1:0] c,
        input logic [CW-1:0] last,
        input logic [42:0]   prod,
        input logic          neg
    );
        logic signed [15:0] q, pred;
        q    = $signed({2'b0, prod[ntm_pkg::RECIP_SH +: 14]});
        pred = neg ? $signed({3'b0, last}) - q : $signed({3'b0, last}) + q;
        return $signed({3'b0, c}) - pred;
    endfunction

    // ---------------- lowest free slot ----------------
    logic          w_has_free;
    logic [SW-1:0] w_free;
    always_comb begin
        w_has_free = 1'b0;
        w_free     = '0;
        for (int i = NT - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                w_has_free = 1'b1;
                w_free     = SW'(i);
            end
        end
    end

    // ---------------- history memory ----------------
    logic              w_mem_we;
    logic [SW-1:0]     w_mem_wa;
    ntm_pkg::t_row     w_mem_wd;
    ntm_pkg::t_row     w_push_row;

    always_comb begin
        w_push_row = r_row;
        if (r_row.cnt >= ntm_pkg::HCNT_W'(ntm_pkg::HIST)) begin
            for (int k = 0; k < ntm_pkg::HIST - 1; k++) begin
                w_push_row.hx[k] = r_row.hx[k+1];
                w_push_row.hy[k] = r_row.hy[k+1];
            end
            w_push_row.hx[ntm_pkg::HIST-1] = r_cx;
            w_push_row.hy[ntm_pkg::HIST-1] = r_cy;
            w_push_row.cnt = ntm_pkg::HCNT_W'(ntm_pkg::HIST);
        end else begin
            w_push_row.hx[r_row.cnt] = r_cx;
            w_push_row.hy[r_row.cnt] = r_cy;
            w_push_row.cnt = r_row.cnt + 1'b1;
        end
    end

    always_comb begin
        w_mem_we = i_cmd.push || i_cmd.open;
        w_mem_wa = i_cmd.push ? r_best : w_free;
        if (i_cmd.push) begin
            w_mem_wd = w_push_row;
        end else begin
            w_mem_wd       = '0;
            w_mem_wd.cnt   = 3'd1;
            w_mem_wd.hx[0] = r_cx;
            w_mem_wd.hy[0] = r_cy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we)
            r_mem[w_mem_wa] <= w_mem_wd;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd || i_cmd.rd_best)
            r_row <= r_mem[i_cmd.rd_best ? r_best : i_cmd.idx];
    end

    // ---------------- pipeline payload ----------------
    logic [28:0] w_d2;
    assign w_d2 = 29'(r_d_sx) + 29'(r_d_sy);

    always_ff @(posedge i_clk) begin
        r_p0_idx <= i_cmd.idx;

        r_a_idx <= r_p0_idx;
        r_a_sx  <= axis_sum(r_row.hx, r_row.cnt);
        r_a_sy  <= axis_sum(r_row.hy, r_row.cnt);
        r_a_lx  <= axis_last(r_row.hx, r_row.cnt);
        r_a_ly  <= axis_last(r_row.hy, r_row.cnt);
        case (r_row.cnt)
            3'd3:    r_a_div <= ntm_pkg::DIV_3;
            3'd4:    r_a_div <= ntm_pkg::DIV_6;
            3'd5:    r_a_div <= ntm_pkg::DIV_10;
            default: r_a_div <= ntm_pkg::DIV_1;
        endcase

        r_b_idx <= r_a_idx;
        r_b_px  <= div_prod(r_a_sx, r_a_div);
        r_b_py  <= div_prod(r_a_sy, r_a_div);
        r_b_nx  <= r_a_sx[17];
        r_b_ny  <= r_a_sy[17];
        r_b_lx  <= r_a_lx;
        r_b_ly  <= r_a_ly;

        r_c_idx <= r_b_idx;
        r_c_dx  <= axis_diff(r_cx, r_b_lx, r_b_px, r_b_nx);
        r_c_dy  <= axis_diff(r_cy, r_b_ly, r_b_py, r_b_ny);

        r_d_idx <= r_c_idx;
        r_d_sx  <= 28'(r_c_dx * r_c_dx);
        r_d_sy  <= 28'(r_c_dy * r_c_dy);

        r_w2 <= r_w * r_w;
        r_h2 <= r_h * r_h;

        if (i_cmd.thr) begin
            r_d2_x400 <= 38'(r_best_d2) * 38'd400;
            r_lim     <= (38'(r_w2) + 38'(r_h2)) * 38'd529;
        end

        if (i_load) begin
            r_cx <= {1'b0, i_box_x} + {2'b0, i_box_width[ntm_pkg::COORD_W-1:1]};
            r_cy <= {1'b0, i_box_y} + {2'b0, i_box_height[ntm_pkg::COORD_W-1:1]};
            r_w  <= i_box_width;
            r_h  <= i_box_height;
        end

        if (r_d_vld && r_valid[r_d_idx] &&
            (!r_found || w_d2 < r_best_d2 ||
             (w_d2 == r_best_d2 && r_order[r_d_idx] < r_best_order))) begin
            r_best       <= r_d_idx;
            r_best_d2    <= w_d2;
            r_best_order <= r_order[r_d_idx];
        end

        if (i_load)
            r_res_slot <= '0;
        else if (i_cmd.push)
            r_res_slot <= r_best;
        else if (i_cmd.open)
            r_res_slot <= w_free;

        if (i_cmd.emit) begin
            o_outcome     <= i_cmd.outcome;
            o_track_slot  <= r_res_slot;
            o_live_tracks <= r_live;
        end
    end

    // ---------------- control state ----------------
    logic [AW-1:0] w_new_age;
    assign w_new_age = (r_age[i_cmd.idx] == ntm_pkg::AGE_MAX) ? ntm_pkg::AGE_MAX
                                                               : r_age[i_cmd.idx] + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_live      <= '0;
            r_first     <= 1'b1;
            r_found     <= 1'b0;
            r_p0_vld    <= 1'b0;
            r_a_vld     <= 1'b0;
            r_b_vld     <= 1'b0;
            r_c_vld     <= 1'b0;
            r_d_vld     <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            r_p0_vld <= i_cmd.rd;
            r_a_vld  <= r_p0_vld;
            r_b_vld  <= r_a_vld;
            r_c_vld  <= r_b_vld;
            r_d_vld  <= r_c_vld;

            if (i_load) begin
                r_found <= 1'b0;
                if (i_kind && r_live != '0)
                    r_first <= 1'b0;
            end else if (r_d_vld && r_valid[r_d_idx]) begin
                r_found <= 1'b1;
            end

            if (i_cmd.open) begin
                r_valid[w_free] <= 1'b1;
                r_order[w_free] <= r_live[SW-1:0];
                r_age[w_free]   <= '0;
                r_live          <= r_live + 1'b1;
            end

            if (i_cmd.push)
                r_age[r_best] <= '0;

            // removal closes the gap in creation order
            if (i_cmd.age && r_valid[i_cmd.idx]) begin
                r_age[i_cmd.idx] <= w_new_age;
                if (w_new_age >= i_lifetime) begin
                    r_valid[i_cmd.idx] <= 1'b0;
                    r_live             <= r_live - 1'b1;
                    for (int j = 0; j < NT; j++) begin
                        if (r_valid[j] && r_order[j] > r_order[i_cmd.idx])
                            r_order[j] <= r_order[j] - 1'b1;
                    end
                end
            end

            if (i_cmd.emit)
                o_out_valid <= 1'b1;
            else if (i_out_ready)
                o_out_valid <= 1'b0;
        end
    end

    always_comb begin
        o_stat.pipe_busy   = r_p0_vld | r_a_vld | r_b_vld | r_c_vld | r_d_vld;
        o_stat.match       = r_found && (r_d2_x400 < r_lim);
        o_stat.has_free    = w_has_free;
        o_stat.first_frame = r_first;
        o_stat.live_zero   = (r_live == '0);
        o_stat.out_hold    = o_out_valid && !i_out_ready;
    end

endmodule

`default_nettype wire

// ===== rtl/nearest_track_matcher.sv =====
// Sequence: a detection runs a scan of every slot and a pipeline drain, then the match decision
// and either a track update or a new track (a drop when no slot is free); in the first frame
// or with no live track a detection opens a track directly; an end of frame ages every slot.
// Flow: one item at a time; the next item is accepted in the cycle after the result
// is loaded, while that result may still wait.
// Reset: synchronous, active low; clears the track table and live count, lifetime to 10.
`timescale 1ns / 1ps
`default_nettype none

// ----------------------------------------------------------------------------
// Nearest track matcher
// Centroid tracker: matches detection boxes to predicted track positions.
// ----------------------------------------------------------------------------
module nearest_track_matcher (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [47:0] i_s_axis_tdata,  // box_x, box_y, box_width, box_height
    input  wire logic        i_s_axis_tuser,  // kind
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [15:0]      o_m_axis_tdata,  // track_slot, live_tracks, zero pad
    output logic [1:0]       o_m_axis_tuser,  // outcome
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [ntm_pkg::AGE_W-1:0]   r_lifetime;
    logic                        w_accept;
    logic                        w_idle;
    ntm_pkg::t_cmd               w_cmd;
    ntm_pkg::t_stat              w_stat;
    logic [ntm_pkg::SLOT_W-1:0]  w_slot;
    logic [ntm_pkg::CNT_W-1:0]   w_live;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == ntm_pkg::REG_LIFETIME) ? {24'b0, r_lifetime} : 32'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_lifetime <= ntm_pkg::LIFETIME_RST;
        else if (psel && penable && pwrite && pready && paddr[2] == ntm_pkg::REG_LIFETIME)
            r_lifetime <= pwdata[ntm_pkg::AGE_W-1:0];
    end

    assign o_s_axis_tready = w_idle && i_rst_n;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;

    ntm_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_kind   (i_s_axis_tuser),
        .i_stat   (w_stat),
        .o_cmd    (w_cmd),
        .o_idle   (w_idle)
    );

    ntm_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (w_accept),
        .i_kind        (i_s_axis_tuser),
        .i_box_x       (i_s_axis_tdata[11:0]),
        .i_box_y       (i_s_axis_tdata[23:12]),
        .i_box_width   (i_s_axis_tdata[35:24]),
        .i_box_height  (i_s_axis_tdata[47:36]),
        .i_lifetime    (r_lifetime),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_out_ready   (i_m_axis_tready),
        .o_out_valid   (o_m_axis_tvalid),
        .o_outcome     (o_m_axis_tuser),
        .o_track_slot  (w_slot),
        .o_live_tracks (w_live)
    );

    assign o_m_axis_tdata = {5'b0, w_live, w_slot};

endmodule

`default_nettype wire

// ===== rtl/ntm_checker.sv =====
// ----------------------------------------------------------------------------
// Nearest track matcher port checker
// Watches the result stream for stall and consistency violations.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "nearest_track_matcher_macros.svh"

module ntm_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_m_axis_tvalid,
    input wire logic        i_m_axis_tready,
    input wire logic [15:0] o_m_axis_tdata,
    input wire logic [1:0]  o_m_axis_tuser
);

    `NTM_ASSERT_NEXT(a_out_hold, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
    `NTM_ASSERT_NOW(a_live_max, o_m_axis_tvalid, o_m_axis_tdata[10:5] <= 6'd32)
    `NTM_ASSERT_NOW(a_slot_zero, o_m_axis_tvalid && (o_m_axis_tuser == ntm_pkg::OUT_DROP || o_m_axis_tuser == ntm_pkg::OUT_CLOSE), o_m_axis_tdata[4:0] == 5'd0)
    `NTM_ASSERT_NOW(a_drop_full, o_m_axis_tvalid && o_m_axis_tuser == ntm_pkg::OUT_DROP, o_m_axis_tdata[10:5] == 6'd32)

endmodule

bind nearest_track_matcher ntm_checker u_ntm_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);

`default_nettype wire
